// ===== hw/rtl/tgc_pkg.sv =====
// ============================================================================
// tgc_pkg
// Shared types, constants and codes for the touch gesture classifier.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tgc_pkg;

	localparam int AVG_COUNT = 8;
	localparam int FILL_W    = $clog2(AVG_COUNT + 1);
	localparam int SUM_W     = 16;
	localparam int COORD_W   = 12;
	localparam int POS_W     = 13;
	localparam int EL_W      = 10;
	localparam int STEP_W    = $clog2(SUM_W);

	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [1:0] REG_CLICK_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_PRESS_DELAY_MS   = 2'd1;
	localparam logic [1:0] REG_DRAG_SPEED_LIMIT = 2'd2;

	localparam logic [7:0]  CLICK_THRESHOLD_RST  = 8'd10;
	localparam logic [11:0] PRESS_DELAY_MS_RST   = 12'd100;
	localparam logic [7:0]  DRAG_SPEED_LIMIT_RST = 8'd50;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_PRESSING = 2'd1,
		PH_DRAGGING = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		G_NONE       = 3'd0,
		G_PRESSED    = 3'd1,
		G_HELD       = 3'd2,
		G_DRAG_START = 3'd3,
		G_DRAG_MOVE  = 3'd4,
		G_CLICKED    = 3'd5,
		G_RELEASED   = 3'd6
	} gesture_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_INIT = 2'd1,
		ST_DIV  = 2'd2,
		ST_FIN  = 2'd3
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0]  click_threshold;
		logic [11:0] press_delay_ms;
		logic [7:0]  drag_speed_limit;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic div_init;
		logic div_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tgc_if.sv =====
// ============================================================================
// tgc_if
// Valid/ready channels for touch samples and gesture results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface tgc_sample_if;
	logic                                valid;
	logic                                ready;
	logic                                touch_valid;
	logic [tgc_pkg::COORD_W-1:0]         touch_x;
	logic [tgc_pkg::COORD_W-1:0]         touch_y;
	logic [tgc_pkg::EL_W-1:0]            elapsed_ms;

	modport source (output valid, touch_valid, touch_x, touch_y, elapsed_ms, input ready);
	modport sink (input valid, touch_valid, touch_x, touch_y, elapsed_ms, output ready);
endinterface

interface tgc_result_if;
	logic                                valid;
	logic                                ready;
	logic [2:0]                          gesture;
	logic signed [tgc_pkg::POS_W-1:0]    pos_x;
	logic signed [tgc_pkg::POS_W-1:0]    pos_y;

	modport source (output valid, gesture, pos_x, pos_y, input ready);
	modport sink (input valid, gesture, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/touch_gesture_classifier.sv =====
// ============================================================================
// touch_gesture_classifier
// Touch sample to gesture classifier with press-qualify delay and averaging.
// ============================================================================
// Takes one touch sample per transaction and returns exactly one gesture
// transaction for it. A sample occupies the block through an accept step, a
// divider load, the bit-serial sum/fill divide (one divider per axis, both
// stepping in lock step) and a commit, which waits while the result channel
// still holds a previous result; the next sample is taken right after the
// commit. Configuration is written through the APB port at byte addresses 0
// (click threshold), 4 (press delay) and 8 (drag speed limit); the user must
// write it only while no sample is in flight, which the block itself does not
// enforce. A new press delay takes effect at the next reload of the qualify
// countdown.
`timescale 1ns / 1ps
`default_nettype none

module touch_gesture_classifier (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tgc_sample_if.sink                         sample,
	tgc_result_if.source                       result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tgc_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [tgc_pkg::DATA_W-1:0]    pwdata,
	output logic      [tgc_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);

	tgc_pkg::cfg_t    cfg;
	tgc_pkg::cmd_t    cmd;
	tgc_pkg::status_t status;
	logic             in_ready;
	logic             out_valid;
	logic [2:0]       out_gesture;
	logic signed [tgc_pkg::POS_W-1:0] out_pos_x, out_pos_y;

	tgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tgc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg         (cfg),
		.touch_valid (sample.touch_valid),
		.touch_x     (sample.touch_x),
		.touch_y     (sample.touch_y),
		.elapsed_ms  (sample.elapsed_ms),
		.out_valid   (out_valid),
		.out_ready   (result.ready),
		.out_gesture (out_gesture),
		.out_pos_x   (out_pos_x),
		.out_pos_y   (out_pos_y)
	);

	assign sample.ready   = in_ready;
	assign result.valid   = out_valid;
	assign result.gesture = out_gesture;
	assign result.pos_x   = out_pos_x;
	assign result.pos_y   = out_pos_y;

endmodule

`default_nettype wire

// ===== hw/rtl/tgc_regs.sv =====
// ============================================================================
// tgc_regs
// APB configuration registers: click threshold, press delay, drag speed limit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tgc_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tgc_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [tgc_pkg::DATA_W-1:0]    pwdata,
	output logic      [tgc_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,
	output tgc_pkg::cfg_t                      cfg
);

	tgc_pkg::cfg_t cfg_q;
	logic [1:0]    idx;
	logic          wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_threshold  <= tgc_pkg::CLICK_THRESHOLD_RST;
			cfg_q.press_delay_ms   <= tgc_pkg::PRESS_DELAY_MS_RST;
			cfg_q.drag_speed_limit <= tgc_pkg::DRAG_SPEED_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				tgc_pkg::REG_CLICK_THRESHOLD:  cfg_q.click_threshold  <= pwdata[7:0];
				tgc_pkg::REG_PRESS_DELAY_MS:   cfg_q.press_delay_ms   <= pwdata[11:0];
				tgc_pkg::REG_DRAG_SPEED_LIMIT: cfg_q.drag_speed_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tgc_pkg::REG_CLICK_THRESHOLD:  prdata = {24'd0, cfg_q.click_threshold};
			tgc_pkg::REG_PRESS_DELAY_MS:   prdata = {20'd0, cfg_q.press_delay_ms};
			tgc_pkg::REG_DRAG_SPEED_LIMIT: prdata = {24'd0, cfg_q.drag_speed_limit};
			default:                       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tgc_ctrl.sv =====
// ============================================================================
// tgc_ctrl
// Sequencer: accept, divider load, bit-serial divide, result commit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tgc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tgc_pkg::status_t   status,
	output tgc_pkg::cmd_t           cmd
);

	tgc_pkg::ctrl_state_t          state_q, state_d;
	logic [tgc_pkg::STEP_W-1:0]    step_q;

	localparam logic [tgc_pkg::STEP_W-1:0] LAST_STEP = tgc_pkg::STEP_W'(tgc_pkg::SUM_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgc_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + 1'b1;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			tgc_pkg::ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid)
					state_d = tgc_pkg::ST_INIT;
			end
			tgc_pkg::ST_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = tgc_pkg::ST_DIV;
			end
			tgc_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LAST_STEP)
					state_d = tgc_pkg::ST_FIN;
			end
			tgc_pkg::ST_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = tgc_pkg::ST_IDLE;
				end
			end
			default: state_d = tgc_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tgc_dp.sv =====
// ============================================================================
// tgc_dp
// Datapath: qualify countdown, averagers, serial dividers, gesture decode,
// result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tgc_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tgc_pkg::cmd_t                     cmd,
	output tgc_pkg::status_t                       status,
	input  wire tgc_pkg::cfg_t                     cfg,
	input  wire logic                              touch_valid,
	input  wire logic [tgc_pkg::COORD_W-1:0]       touch_x,
	input  wire logic [tgc_pkg::COORD_W-1:0]       touch_y,
	input  wire logic [tgc_pkg::EL_W-1:0]          elapsed_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [2:0]                             out_gesture,
	output logic signed [tgc_pkg::POS_W-1:0]       out_pos_x,
	output logic signed [tgc_pkg::POS_W-1:0]       out_pos_y
);

	localparam int CW = tgc_pkg::COORD_W;
	localparam int SW = tgc_pkg::SUM_W;
	localparam int FW = tgc_pkg::FILL_W;
	localparam int PW = tgc_pkg::POS_W;
	localparam logic [FW-1:0] AVG_FULL = FW'(tgc_pkg::AVG_COUNT);
	localparam logic [SW-1:0] AVG_DIV  = SW'(tgc_pkg::AVG_COUNT);

	// per-sample state
	logic [CW-1:0]     rx_q, ry_q;
	logic              qual_q;
	logic [11:0]       qrem_q;
	logic [11:0]       qrem_dec;

	// averagers
	logic [SW-1:0]     sum_x_q, sum_y_q;
	logic [FW-1:0]     fill_q;
	logic [SW-1:0]     sum_x_d, sum_y_d;
	logic [FW-1:0]     fill_d;

	// dividers
	logic [SW-1:0]     quot_x_q, quot_y_q;
	logic [FW-1:0]     rem_x_q, rem_y_q;
	logic [SW-1:0]     quot_x_d, quot_y_d;
	logic [FW-1:0]     rem_x_d, rem_y_d;

	// gesture state
	tgc_pkg::phase_t   phase_q, phase_d;
	logic [CW-1:0]     press_x_q, press_y_q, last_x_q, last_y_q;
	logic [CW-1:0]     press_x_d, press_y_d, last_x_d, last_y_d;
	logic              lost;

	logic [CW-1:0]     ax, ay;
	tgc_pkg::gesture_t g;
	logic [PW-1:0]     ox, oy;
	logic [PW-1:0]     dx, dy;

	logic              out_valid_q;
	logic [2:0]        gest_q;
	logic [PW-1:0]     pos_x_q, pos_y_q;

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign qrem_dec = (qrem_q > {2'b00, elapsed_ms}) ? qrem_q - {2'b00, elapsed_ms} : '0;

	always_comb begin
		if (fill_q < AVG_FULL) begin
			fill_d  = fill_q + 1'b1;
			sum_x_d = sum_x_q + SW'(touch_x);
			sum_y_d = sum_y_q + SW'(touch_y);
		end else begin
			fill_d  = fill_q;
			sum_x_d = sum_x_q - sum_x_q / AVG_DIV + SW'(touch_x);
			sum_y_d = sum_y_q - sum_y_q / AVG_DIV + SW'(touch_y);
		end
	end

	// one restoring-division step per axis
	always_comb begin
		logic [FW:0] tx, ty;
		tx       = {rem_x_q, quot_x_q[SW-1]};
		ty       = {rem_y_q, quot_y_q[SW-1]};
		quot_x_d = {quot_x_q[SW-2:0], tx >= {1'b0, fill_q}};
		quot_y_d = {quot_y_q[SW-2:0], ty >= {1'b0, fill_q}};
		rem_x_d  = (tx >= {1'b0, fill_q}) ? FW'(tx - {1'b0, fill_q}) : tx[FW-1:0];
		rem_y_d  = (ty >= {1'b0, fill_q}) ? FW'(ty - {1'b0, fill_q}) : ty[FW-1:0];
	end

	assign ax = quot_x_q[CW-1:0];
	assign ay = quot_y_q[CW-1:0];
	assign dx = {1'b0, ax} - {1'b0, last_x_q};
	assign dy = {1'b0, ay} - {1'b0, last_y_q};

	always_comb begin
		g         = tgc_pkg::G_NONE;
		ox        = {1'b0, rx_q};
		oy        = {1'b0, ry_q};
		phase_d   = phase_q;
		press_x_d = press_x_q;
		press_y_d = press_y_q;
		last_x_d  = last_x_q;
		last_y_d  = last_y_q;
		lost      = 1'b0;
		if (qual_q) begin
			case (phase_q)
				tgc_pkg::PH_PRESSING: begin
					if (abs_diff(press_x_q, ax) > CW'(cfg.click_threshold) ||
					    abs_diff(press_y_q, ay) > CW'(cfg.click_threshold)) begin
						g        = tgc_pkg::G_DRAG_START;
						last_x_d = ax;
						last_y_d = ay;
						ox       = '0;
						oy       = '0;
						phase_d  = tgc_pkg::PH_DRAGGING;
					end else begin
						g  = tgc_pkg::G_HELD;
						ox = {1'b0, press_x_q};
						oy = {1'b0, press_y_q};
					end
				end
				tgc_pkg::PH_DRAGGING: begin
					g = tgc_pkg::G_DRAG_MOVE;
					if (abs_diff(ax, last_x_q) > CW'(cfg.drag_speed_limit) ||
					    abs_diff(ay, last_y_q) > CW'(cfg.drag_speed_limit)) begin
						ox = '0;
						oy = '0;
					end else begin
						ox = dx;
						oy = dy;
					end
					last_x_d = ax;
					last_y_d = ay;
				end
				default: begin
					press_x_d = ax;
					press_y_d = ay;
					g         = tgc_pkg::G_PRESSED;
					ox        = {1'b0, ax};
					oy        = {1'b0, ay};
					phase_d   = tgc_pkg::PH_PRESSING;
				end
			endcase
		end else if (phase_q != tgc_pkg::PH_RELEASED) begin
			g       = (phase_q == tgc_pkg::PH_PRESSING) ? tgc_pkg::G_CLICKED
			                                            : tgc_pkg::G_RELEASED;
			ox      = {1'b0, press_x_q};
			oy      = {1'b0, press_y_q};
			lost    = 1'b1;
			phase_d = tgc_pkg::PH_RELEASED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qrem_q    <= tgc_pkg::PRESS_DELAY_MS_RST;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			fill_q    <= '0;
			phase_q   <= tgc_pkg::PH_RELEASED;
			press_x_q <= '0;
			press_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			qual_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				qrem_q <= qrem_dec;
				qual_q <= touch_valid && (qrem_dec == '0);
				if (touch_valid && (qrem_dec == '0)) begin
					sum_x_q <= sum_x_d;
					sum_y_q <= sum_y_d;
					fill_q  <= fill_d;
				end
			end
			if (cmd.commit) begin
				phase_q   <= phase_d;
				press_x_q <= press_x_d;
				press_y_q <= press_y_d;
				last_x_q  <= last_x_d;
				last_y_q  <= last_y_d;
				if (lost) begin
					qrem_q  <= cfg.press_delay_ms;
					sum_x_q <= '0;
					sum_y_q <= '0;
					fill_q  <= '0;
				end
			end
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rx_q <= touch_x;
			ry_q <= touch_y;
		end
		if (cmd.div_init) begin
			quot_x_q <= sum_x_q;
			quot_y_q <= sum_y_q;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
		end else if (cmd.div_step) begin
			quot_x_q <= quot_x_d;
			quot_y_q <= quot_y_d;
			rem_x_q  <= rem_x_d;
			rem_y_q  <= rem_y_d;
		end
		if (cmd.commit) begin
			gest_q  <= g;
			pos_x_q <= ox;
			pos_y_q <= oy;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_gesture     = gest_q;
	assign out_pos_x       = pos_x_q;
	assign out_pos_y       = pos_y_q;

endmodule

`default_nettype wire

// ===== test/tb_touch_gesture_classifier.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_touch_gesture_classifier
// Self-checking bench for the touch gesture classifier.
// ============================================================================
// Touch samples come from a queue. Each accepted sample runs through a local
// copy of the classifier, and the gesture it predicts is stored. Every result
// transaction is compared with the oldest stored gesture. A directed burst
// comes first. Random phases follow under several register settings, the
// extremes among them. Both channels idle at random.
module tb_touch_gesture_classifier;
	import tgc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic               touch_valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [EL_W-1:0]    elapsed;
	} touch_sample_t;

	typedef struct packed {
		gesture_t                gesture;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} gesture_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic          sample_valid = 1'b0;
	touch_sample_t sample_q = '0;
	logic          result_ready = 1'b0;

	int  cycle_count = 0;
	int  stall_cycles = 0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  mismatch_count = 0;
	int  queued_count = 0;
	logic quiet;

	touch_sample_t pending_samples[$];
	gesture_rec_t  expected_gestures[$];

	// classifier copy: registers and state
	logic [7:0]         cfg_click = CLICK_THRESHOLD_RST;
	logic [11:0]        cfg_delay = PRESS_DELAY_MS_RST;
	logic [7:0]         cfg_speed = DRAG_SPEED_LIMIT_RST;
	phase_t             phase = PH_RELEASED;
	logic [COORD_W-1:0] press_x = '0;
	logic [COORD_W-1:0] press_y = '0;
	logic [COORD_W-1:0] drag_x = '0;
	logic [COORD_W-1:0] drag_y = '0;
	logic [11:0]        qualify_left = PRESS_DELAY_MS_RST;
	logic [SUM_W-1:0]   sum_x = '0;
	logic [SUM_W-1:0]   sum_y = '0;
	logic [FILL_W-1:0]  fill = '0;

	tgc_sample_if smp ();
	tgc_result_if res ();

	assign smp.valid       = sample_valid;
	assign smp.touch_valid = sample_q.touch_valid;
	assign smp.touch_x     = sample_q.x;
	assign smp.touch_y     = sample_q.y;
	assign smp.elapsed_ms  = sample_q.elapsed;
	assign res.ready       = result_ready;

	assign quiet = (cycle_count >= 4000) && (cycle_count < 10000);

	touch_gesture_classifier u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	function automatic logic [COORD_W-1:0] coord_dist(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic gesture_rec_t classify_sample(input touch_sample_t s);
		gesture_rec_t       r;
		logic [SUM_W-1:0]   qx;
		logic [SUM_W-1:0]   qy;
		logic [COORD_W-1:0] ax;
		logic [COORD_W-1:0] ay;
		r.gesture = G_NONE;
		r.pos_x = {1'b0, s.x};
		r.pos_y = {1'b0, s.y};
		qualify_left = (qualify_left > s.elapsed) ? qualify_left - s.elapsed : '0;
		if (s.touch_valid && qualify_left == '0) begin
			if (fill < AVG_COUNT) begin
				fill = fill + 1'b1;
				sum_x = sum_x + s.x;
				sum_y = sum_y + s.y;
			end else begin
				sum_x = sum_x - sum_x / AVG_COUNT + s.x;
				sum_y = sum_y - sum_y / AVG_COUNT + s.y;
			end
			qx = sum_x / fill;
			qy = sum_y / fill;
			ax = qx[COORD_W-1:0];
			ay = qy[COORD_W-1:0];
			case (phase)
				PH_PRESSING: begin
					if (coord_dist(press_x, ax) > cfg_click || coord_dist(press_y, ay) > cfg_click) begin
						r.gesture = G_DRAG_START;
						r.pos_x = '0;
						r.pos_y = '0;
						drag_x = ax;
						drag_y = ay;
						phase = PH_DRAGGING;
					end else begin
						r.gesture = G_HELD;
						r.pos_x = {1'b0, press_x};
						r.pos_y = {1'b0, press_y};
					end
				end
				PH_DRAGGING: begin
					r.gesture = G_DRAG_MOVE;
					if (coord_dist(ax, drag_x) > cfg_speed || coord_dist(ay, drag_y) > cfg_speed) begin
						r.pos_x = '0;
						r.pos_y = '0;
					end else begin
						r.pos_x = {1'b0, ax} - {1'b0, drag_x};
						r.pos_y = {1'b0, ay} - {1'b0, drag_y};
					end
					drag_x = ax;
					drag_y = ay;
				end
				default: begin
					r.gesture = G_PRESSED;
					r.pos_x = {1'b0, ax};
					r.pos_y = {1'b0, ay};
					press_x = ax;
					press_y = ay;
					phase = PH_PRESSING;
				end
			endcase
		end else if (phase != PH_RELEASED) begin
			if (phase == PH_PRESSING) begin
				r.gesture = G_CLICKED;
			end else begin
				r.gesture = G_RELEASED;
			end
			r.pos_x = {1'b0, press_x};
			r.pos_y = {1'b0, press_y};
			qualify_left = cfg_delay;
			sum_x = '0;
			sum_y = '0;
			fill = '0;
			phase = PH_RELEASED;
		end
		return r;
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	task automatic queue_sample(input bit tv, input int x, input int y, input int el);
		touch_sample_t s;
		s.touch_valid = tv;
		s.x = (x < 0) ? '0 : (x > 4095) ? 12'd4095 : x[COORD_W-1:0];
		s.y = (y < 0) ? '0 : (y > 4095) ? 12'd4095 : y[COORD_W-1:0];
		s.elapsed = (el > 1023) ? 10'd1023 : el[EL_W-1:0];
		pending_samples.push_back(s);
		queued_count++;
	endtask

	// release gap, press with jitter, optional drag, then lift
	task automatic queue_touch_sequence();
		int px;
		int py;
		int reach;
		int stride;
		px = $urandom_range(0, 4095);
		py = $urandom_range(0, 4095);
		repeat ($urandom_range(0, 5))
			queue_sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(cfg_delay / 4, cfg_delay / 2 + 8));
		repeat ($urandom_range(1, 6))
			queue_sample(1'b1, px + jitter(cfg_click / 2), py + jitter(cfg_click / 2),
				$urandom_range(0, 40));
		if ($urandom_range(0, 3) != 0) begin
			reach = 3 * cfg_click + $urandom_range(8, 60);
			px = px + ($urandom_range(0, 1) ? reach : -reach);
			py = py + jitter(reach);
			repeat ($urandom_range(1, 3))
				queue_sample(1'b1, px, py, $urandom_range(0, 40));
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 5) == 0) begin
					stride = 4 * cfg_speed + $urandom_range(8, 200);
				end else begin
					stride = $urandom_range(0, cfg_speed);
				end
				px = px + jitter(stride);
				py = py + jitter(stride);
				queue_sample(1'b1, px, py, $urandom_range(0, 40));
			end
		end
		queue_sample(1'b0, px, py, $urandom_range(0, 40));
	endtask

	task automatic queue_random_phase(input int count);
		queued_count = 0;
		while (queued_count < count) begin
			if ($urandom_range(0, 99) < 15) begin
				queue_sample($urandom_range(0, 1), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 1023));
			end else begin
				queue_touch_sequence();
			end
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || sample_valid || expected_gestures.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CLICK_THRESHOLD:  cfg_click = value[7:0];
			REG_PRESS_DELAY_MS:   cfg_delay = value[11:0];
			REG_DRAG_SPEED_LIMIT: cfg_speed = value[7:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [7:0] thr, input logic [11:0] dly, input logic [7:0] spd);
		wait_idle();
		write_reg(REG_CLICK_THRESHOLD, DATA_W'(thr));
		write_reg(REG_PRESS_DELAY_MS, DATA_W'(dly));
		write_reg(REG_DRAG_SPEED_LIMIT, DATA_W'(spd));
		@(negedge clk);
	endtask

	task automatic flag_mismatch();
		mismatch_count++;
	endtask

	// sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
			end else if (!quiet && $urandom_range(0, 149) == 0) begin
				send_gap <= $urandom_range(1, 20);
			end
			if (!sample_valid || smp.ready) begin
				if (sample_valid)
					expected_gestures.push_back(classify_sample(sample_q));
				if (pending_samples.size() != 0 && send_gap == 0) begin
					sample_q <= pending_samples.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		gesture_rec_t want;
		if (arst_n) begin
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
			end else if (!quiet && $urandom_range(0, 149) == 0) begin
				recv_gap <= $urandom_range(1, 20);
			end
			result_ready <= (recv_gap == 0);
			if (res.valid && result_ready) begin
				if (expected_gestures.size() == 0) begin
					flag_mismatch();
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected gesture transaction %0d (%0d, %0d)",
							$time, res.gesture, res.pos_x, res.pos_y);
				end else begin
					want = expected_gestures.pop_front();
					if (res.gesture !== want.gesture || res.pos_x !== want.pos_x ||
							res.pos_y !== want.pos_y) begin
						flag_mismatch();
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: gesture mismatch: expected %0d (%0d, %0d), got %0d (%0d, %0d)",
								$time, want.gesture, want.pos_x, want.pos_y,
								res.gesture, res.pos_x, res.pos_y);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n || (sample_valid && smp.ready) || (res.valid && result_ready) ||
				(psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no touch: raw position passes through, countdown runs out
		queue_sample(1'b0, 0, 0, 0);
		queue_sample(1'b0, 4095, 4095, 1023);
		// press at far corner, jump to origin starts a drag
		queue_sample(1'b1, 4095, 4095, 0);
		queue_sample(1'b1, 0, 0, 1023);
		// speed-limited moves, then the averager fills and slides
		repeat (10) queue_sample(1'b1, 0, 0, 5);
		// lost while dragging
		queue_sample(1'b0, 100, 200, 0);
		// touch before the delay ends, then qualified press, hold, click
		queue_sample(1'b1, 300, 300, 0);
		queue_sample(1'b1, 300, 300, 100);
		queue_sample(1'b1, 305, 296, 1);
		queue_sample(1'b0, 0, 0, 0);

		configure(8'd0, 12'd0, 8'd0);
		queue_random_phase(150);
		configure(8'd255, 12'd4095, 8'd255);
		queue_random_phase(150);
		configure(8'd20, 12'd50, 8'd100);
		queue_random_phase(150);
		wait_idle();
		queue_random_phase(150);
		configure(8'($urandom_range(0, 255)), 12'($urandom_range(0, 400)),
			8'($urandom_range(0, 255)));
		queue_random_phase(300);

		wait_idle();
		repeat (25) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tgc_pkg.sv
hw/rtl/tgc_if.sv
hw/rtl/tgc_regs.sv
hw/rtl/tgc_ctrl.sv
hw/rtl/tgc_dp.sv
hw/rtl/touch_gesture_classifier.sv
test/tb_touch_gesture_classifier.sv
